// File: design/cnpt_pkg.sv
package cnpt_pkg;

  localparam int ACTION_W    = 2;
  localparam int INDEX_W     = 6;
  localparam int DIST_W      = 24;
  localparam int MASK_W      = 64;
  localparam int DIST_MAX_W  = 32;
  localparam int ADDR_EXT_W  = 16;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_CLEAR = 2'd0,
    ACT_ADD   = 2'd1,
    ACT_LOAD  = 2'd2,
    ACT_MOVE  = 2'd3
  } action_t;

  // classified operation; NOP covers out-of-range centres or particles
  typedef enum logic [2:0] {
    OP_NOP,
    OP_CLEAR,
    OP_ADD,
    OP_LOAD,
    OP_MOVE
  } op_t;

  typedef struct packed {
    op_t                   op;
    logic [INDEX_W-1:0]    center;
    logic [INDEX_W-1:0]    particle;
    logic [DIST_MAX_W-1:0] old_dist;
    logic [DIST_MAX_W-1:0] new_dist;
    logic [DIST_MAX_W-1:0] cutoff;
  } cmd_t;

  typedef enum logic {
    B_IDLE,
    B_EXEC
  } back_state_t;

endpackage

// File: design/cnpt_if.sv
interface cnpt_in_if;
  logic                        valid;
  logic                        ready;
  logic [cnpt_pkg::ACTION_W-1:0] action;
  logic [cnpt_pkg::INDEX_W-1:0]  particle_index;
  logic [cnpt_pkg::INDEX_W-1:0]  center_index;
  logic [cnpt_pkg::DIST_W-1:0]   dist_before;
  logic [cnpt_pkg::DIST_W-1:0]   dist_after;
  logic [cnpt_pkg::DIST_W-1:0]   cutoff_value;

  modport source (
    output valid, action, particle_index, center_index, dist_before, dist_after,
           cutoff_value,
    input  ready
  );
  modport sink (
    input  valid, action, particle_index, center_index, dist_before, dist_after,
           cutoff_value,
    output ready
  );
endinterface

interface cnpt_out_if;
  logic                        valid;
  logic                        ready;
  logic [cnpt_pkg::MASK_W-1:0] affected_mask;
  logic                        pair_missing;

  modport source (output valid, affected_mask, pair_missing, input ready);
  modport sink   (input valid, affected_mask, pair_missing, output ready);
endinterface

// File: design/cnpt_front.sv
module cnpt_front #(
  parameter int NUM_PARTICLES = 64,
  parameter int NUM_CENTERS   = 64,
  parameter int DIST_BITS     = 24
) (
  cnpt_in_if.sink         item,
  input  logic            q_full,
  output logic            q_push,
  output cnpt_pkg::cmd_t  q_cmd
);

  localparam logic [cnpt_pkg::DIST_MAX_W-1:0] DIST_MASK =
    cnpt_pkg::DIST_MAX_W'((64'd1 << DIST_BITS) - 64'd1);

  logic c_ok;
  logic p_ok;

  assign item.ready = !q_full;
  assign q_push     = item.valid && !q_full;

  assign c_ok = 32'(item.center_index) < 32'(NUM_CENTERS);
  assign p_ok = 32'(item.particle_index) < 32'(NUM_PARTICLES);

  always_comb begin
    q_cmd.center   = item.center_index;
    q_cmd.particle = item.particle_index;
    q_cmd.old_dist = cnpt_pkg::DIST_MAX_W'(item.dist_before) & DIST_MASK;
    q_cmd.new_dist = cnpt_pkg::DIST_MAX_W'(item.dist_after) & DIST_MASK;
    q_cmd.cutoff   = cnpt_pkg::DIST_MAX_W'(item.cutoff_value) & DIST_MASK;
    unique case (cnpt_pkg::action_t'(item.action))
      cnpt_pkg::ACT_CLEAR: q_cmd.op = cnpt_pkg::OP_CLEAR;
      cnpt_pkg::ACT_ADD:   q_cmd.op = (c_ok && p_ok) ? cnpt_pkg::OP_ADD : cnpt_pkg::OP_NOP;
      cnpt_pkg::ACT_LOAD:  q_cmd.op = c_ok ? cnpt_pkg::OP_LOAD : cnpt_pkg::OP_NOP;
      cnpt_pkg::ACT_MOVE:  q_cmd.op = (c_ok && p_ok) ? cnpt_pkg::OP_MOVE : cnpt_pkg::OP_NOP;
      default:             q_cmd.op = cnpt_pkg::OP_NOP;
    endcase
  end

endmodule

// File: design/cnpt_queue.sv
module cnpt_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  cnpt_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output cnpt_pkg::cmd_t head
);

  localparam int AW = (cnpt_pkg::QUEUE_DEPTH > 1) ? $clog2(cnpt_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(cnpt_pkg::QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(cnpt_pkg::QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(cnpt_pkg::QUEUE_DEPTH);

  cnpt_pkg::cmd_t  entries [cnpt_pkg::QUEUE_DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  assign full      = count == DEPTH_C;
  assign not_empty = count != '0;
  assign head      = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: design/cnpt_back.sv
module cnpt_back #(
  parameter int NUM_PARTICLES = 64,
  parameter int NUM_CENTERS   = 64,
  parameter int DIST_BITS     = 24
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  cnpt_pkg::cmd_t  q_cmd,
  output logic            q_pop,
  cnpt_out_if.source      result
);

  localparam int CW = (NUM_CENTERS > 1) ? $clog2(NUM_CENTERS) : 1;

  function automatic logic [CW-1:0] addr_of(input logic [cnpt_pkg::INDEX_W-1:0] c);
    logic [cnpt_pkg::ADDR_EXT_W-1:0] ext;
    ext = cnpt_pkg::ADDR_EXT_W'(c);
    return ext[CW-1:0];
  endfunction

  logic [NUM_PARTICLES-1:0] row_mem [NUM_CENTERS];
  logic [DIST_BITS-1:0]     cut_mem [NUM_CENTERS];
  logic [NUM_CENTERS-1:0]   row_valid;
  logic [NUM_CENTERS-1:0]   cut_valid;

  cnpt_pkg::back_state_t state, state_next;
  cnpt_pkg::cmd_t        cmd;
  logic [NUM_PARTICLES-1:0] rd_row;
  logic [DIST_BITS-1:0]     rd_cut;

  logic [CW-1:0]            q_addr;
  logic [CW-1:0]            e_addr;
  logic [NUM_PARTICLES-1:0] row_cur;
  logic [DIST_BITS-1:0]     cut_cur;
  logic [NUM_PARTICLES-1:0] p_bit;
  logic                     old_in;
  logic                     new_in;
  logic                     out_free;

  logic                     exec;
  logic                     row_we;
  logic [NUM_PARTICLES-1:0] row_wdata;
  logic                     cut_we;
  logic                     clr_all;
  logic [NUM_PARTICLES-1:0] mask;
  logic                     missing;

  logic                      res_valid;
  logic [cnpt_pkg::MASK_W-1:0] res_mask;
  logic                      res_missing;

  assign q_addr   = addr_of(q_cmd.center);
  assign e_addr   = addr_of(cmd.center);
  assign row_cur  = row_valid[e_addr] ? rd_row : '0;
  assign cut_cur  = cut_valid[e_addr] ? rd_cut : '0;
  assign p_bit    = (NUM_PARTICLES)'(1) << cmd.particle;
  assign old_in   = cmd.old_dist[DIST_BITS-1:0] < cut_cur;
  assign new_in   = cmd.new_dist[DIST_BITS-1:0] < cut_cur;
  assign out_free = !res_valid || result.ready;

  always_comb begin
    unique case (state)
      cnpt_pkg::B_IDLE: state_next = (q_valid && out_free) ? cnpt_pkg::B_EXEC : cnpt_pkg::B_IDLE;
      cnpt_pkg::B_EXEC: state_next = cnpt_pkg::B_IDLE;
      default:          state_next = cnpt_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = (state == cnpt_pkg::B_IDLE) && q_valid && out_free;
    exec      = state == cnpt_pkg::B_EXEC;
    row_we    = 1'b0;
    row_wdata = row_cur;
    cut_we    = 1'b0;
    clr_all   = 1'b0;
    mask      = '0;
    missing   = 1'b0;
    if (exec) begin
      unique case (cmd.op)
        cnpt_pkg::OP_CLEAR: clr_all = 1'b1;
        cnpt_pkg::OP_ADD: begin
          row_we    = 1'b1;
          row_wdata = row_cur | p_bit;
        end
        cnpt_pkg::OP_LOAD: cut_we = 1'b1;
        cnpt_pkg::OP_MOVE: begin
          // zero cutoff: centre skipped
          if (cut_cur != '0) begin
            priority if (old_in && !new_in) begin
              missing   = (row_cur & p_bit) == '0;
              row_we    = 1'b1;
              row_wdata = row_cur & ~p_bit;
              mask      = p_bit | (row_cur & ~p_bit);
            end else if (!old_in && new_in) begin
              row_we    = 1'b1;
              row_wdata = row_cur | p_bit;
              mask      = row_cur | p_bit;
            end else if (old_in && new_in) begin
              mask = row_cur;
            end else begin
              mask = '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cnpt_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd    <= q_cmd;
      rd_row <= row_mem[q_addr];
      rd_cut <= cut_mem[q_addr];
    end
    if (row_we) begin
      row_mem[e_addr] <= row_wdata;
    end
    if (cut_we) begin
      cut_mem[e_addr] <= cmd.cutoff[DIST_BITS-1:0];
    end
  end

  // an entry without its valid bit reads as zero; clear drops the row bits only
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      cut_valid <= '0;
    end else begin
      if (clr_all) begin
        row_valid <= '0;
      end
      if (row_we) begin
        row_valid[e_addr] <= 1'b1;
      end
      if (cut_we) begin
        cut_valid[e_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (exec) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      res_mask    <= cnpt_pkg::MASK_W'(mask);
      res_missing <= missing;
    end
  end

  assign result.valid         = res_valid;
  assign result.affected_mask = res_mask;
  assign result.pair_missing  = res_missing;

  a_exec_out_free: assert property (@(posedge clk) disable iff (rst)
    state == cnpt_pkg::B_EXEC |-> !res_valid)
    else $error("execute with result register still occupied");

  a_exec_gives_result: assert property (@(posedge clk) disable iff (rst)
    state == cnpt_pkg::B_EXEC |=> res_valid)
    else $error("executed request produced no result");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (state == cnpt_pkg::B_EXEC && cmd.op == cnpt_pkg::OP_CLEAR) |=> row_valid == '0)
    else $error("clear left a valid row");

  a_non_move_zero: assert property (@(posedge clk) disable iff (rst)
    (state == cnpt_pkg::B_EXEC && cmd.op != cnpt_pkg::OP_MOVE)
      |=> (res_mask == '0 && !res_missing))
    else $error("non-update request gave a non-zero result");

endmodule

// File: design/cutoff_neighbor_pair_tracker_core.sv
// Pair tracker: a front end classifies each request and parks it in a two-entry
// queue; the back end takes one request at a time: the idle state pops it with a
// registered read of the centre's member row and cutoff, the execute state
// computes and writes back, and no new request is taken before that is done.
// With an empty queue and a free output the request passes the queue entry, the
// registered read and then the result register. Reset of both tables and the
// clear-all of the member rows use per-centre valid bits, so there is no clearing
// pass. The back end takes the next request only when the result register is
// empty or being emptied in that cycle, so a stalled result holds the back end
// while the queue still takes up to two requests.
module cutoff_neighbor_pair_tracker_core #(
  parameter int NUM_PARTICLES = 64,
  parameter int NUM_CENTERS   = 64,
  parameter int DIST_BITS     = 24
) (
  input  logic       clk,
  input  logic       rst,
  cnpt_in_if.sink    item,
  cnpt_out_if.source result
);

  logic           q_full;
  logic           q_push;
  cnpt_pkg::cmd_t q_in;
  logic           q_pop;
  logic           q_valid;
  cnpt_pkg::cmd_t q_head;

  cnpt_front #(
    .NUM_PARTICLES (NUM_PARTICLES),
    .NUM_CENTERS   (NUM_CENTERS),
    .DIST_BITS     (DIST_BITS)
  ) u_front (
    .item   (item),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (q_in)
  );

  cnpt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  cnpt_back #(
    .NUM_PARTICLES (NUM_PARTICLES),
    .NUM_CENTERS   (NUM_CENTERS),
    .DIST_BITS     (DIST_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_cmd   (q_head),
    .q_pop   (q_pop),
    .result  (result)
  );

endmodule
